// ===== sv/wmp_pkg.sv =====
// shared constants and helpers for the weighted motion predictor
`default_nettype none

package wmp_pkg;

  // default coordinate width and history depth
  localparam int COORD_W_DEF     = 12;
  localparam int HIST_DEPTH      = 5;
  localparam int QUEUE_DEPTH_DEF = 2;

  // prediction and count widths
  localparam int PRED_W = 14;
  localparam int CNT_W  = 3;

  // history counts
  localparam logic [CNT_W-1:0] CNT_0 = 3'd0;
  localparam logic [CNT_W-1:0] CNT_1 = 3'd1;
  localparam logic [CNT_W-1:0] CNT_2 = 3'd2;
  localparam logic [CNT_W-1:0] CNT_3 = 3'd3;
  localparam logic [CNT_W-1:0] CNT_4 = 3'd4;
  localparam logic [CNT_W-1:0] CNT_5 = 3'd5;

  // width of the weighted sum: |sum| stays below 4 * 2^w
  function automatic int sum_width(input int w);
    return w + 3;
  endfunction

  // queue entry: two sums, two last centers, count
  function automatic int entry_width(input int w);
    return 2 * sum_width(w) + 2 * w + CNT_W;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wmp_queue.sv =====
// small register queue between the front and the back
`default_nettype none

module wmp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);
  import wmp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // handshake qualification
  assign full    = (cnt_r == FULL_CNT);
  assign valid   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wmp_front.sv =====
// front: center history, point count and weighted difference sums
`default_nettype none

module wmp_front #(
  parameter int COORD_WIDTH = wmp_pkg::COORD_W_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          accept,
  input  logic                                          new_track,
  input  logic [COORD_WIDTH-1:0]                        center_x,
  input  logic [COORD_WIDTH-1:0]                        center_y,
  output logic [wmp_pkg::entry_width(COORD_WIDTH)-1:0] entry
);
  import wmp_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int SW = sum_width(COORD_WIDTH);

  logic [W-1:0]     hx_r [HIST_DEPTH];
  logic [W-1:0]     hy_r [HIST_DEPTH];
  logic [W-1:0]     hx_nxt [HIST_DEPTH];
  logic [W-1:0]     hy_nxt [HIST_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [SW-1:0] sum_x, sum_y;

  // weights telescope: n points give (n-1)*h0 - h1 - ... - h(n-1)
  function automatic logic signed [SW-1:0] wsum(
    input logic [W-1:0]     h0,
    input logic [W-1:0]     h1,
    input logic [W-1:0]     h2,
    input logic [W-1:0]     h3,
    input logic [W-1:0]     h4,
    input logic [CNT_W-1:0] n
  );
    logic signed [SW-1:0] e0, e1, e2, e3, e4, r;
    e0 = SW'($signed({1'b0, h0}));
    e1 = SW'($signed({1'b0, h1}));
    e2 = SW'($signed({1'b0, h2}));
    e3 = SW'($signed({1'b0, h3}));
    e4 = SW'($signed({1'b0, h4}));
    case (n)
      CNT_2:   r = e0 - e1;
      CNT_3:   r = (e0 <<< 1) - e1 - e2;
      CNT_4:   r = (e0 <<< 1) + e0 - e1 - e2 - e3;
      CNT_5:   r = (e0 <<< 2) - e1 - e2 - e3 - e4;
      default: r = '0;
    endcase
    return r;
  endfunction

  // shifted history and saturating count
  always_comb begin
    hx_nxt[0] = center_x;
    hy_nxt[0] = center_y;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      hx_nxt[i] = hx_r[i-1];
      hy_nxt[i] = hy_r[i-1];
    end
    if (new_track) begin
      cnt_nxt = CNT_1;
    end else if (cnt_r == CNT_5) begin
      cnt_nxt = CNT_5;
    end else begin
      cnt_nxt = cnt_r + CNT_1;
    end
  end

  // weighted sums on the updated history
  assign sum_x = wsum(hx_nxt[0], hx_nxt[1], hx_nxt[2], hx_nxt[3], hx_nxt[4], cnt_nxt);
  assign sum_y = wsum(hy_nxt[0], hy_nxt[1], hy_nxt[2], hy_nxt[3], hy_nxt[4], cnt_nxt);
  assign entry = {sum_x, sum_y, center_x, center_y, cnt_nxt};

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  // history registers, entries beyond the count are never used
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hx_r[i] <= hx_nxt[i];
        hy_r[i] <= hy_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/wmp_back.sv =====
// back: rounded division by 3, 6 or 10 and final add, with output register
`default_nettype none

module wmp_back #(
  parameter int COORD_WIDTH = wmp_pkg::COORD_W_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_valid,
  input  logic [wmp_pkg::entry_width(COORD_WIDTH)-1:0] q_data,
  output logic                                          q_pop,
  output logic                                          out_empty,
  input  logic                                          out_pop,
  output logic signed [wmp_pkg::PRED_W-1:0]             out_predicted_x,
  output logic signed [wmp_pkg::PRED_W-1:0]             out_predicted_y,
  output logic [wmp_pkg::CNT_W-1:0]                     out_history_count
);
  import wmp_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int SW = sum_width(COORD_WIDTH);
  // shift of the reciprocals: exact floor for numerators below 2^SW
  localparam int K  = SW + 4;
  localparam int PW = SW + K;
  localparam int AW = W + PRED_W;

  localparam logic [K-1:0] RECIP_3  = K'(((64'd1 << K) + 64'd2) / 64'd3);
  localparam logic [K-1:0] RECIP_6  = K'(((64'd1 << K) + 64'd5) / 64'd6);
  localparam logic [K-1:0] RECIP_10 = K'(((64'd1 << K) + 64'd9) / 64'd10);
  localparam logic [SW-1:0] HALF_3  = SW'(1);
  localparam logic [SW-1:0] HALF_6  = SW'(3);
  localparam logic [SW-1:0] HALF_10 = SW'(5);

  logic signed [SW-1:0] in_sx, in_sy;
  logic [W-1:0]         in_lx, in_ly;
  logic [CNT_W-1:0]     in_cnt;

  logic                 s1_v_r;
  logic [PW-1:0]        prod_x_r, prod_y_r;
  logic signed [SW-1:0] sx_r, sy_r;
  logic [W-1:0]         lx_r, ly_r;
  logic [CNT_W-1:0]     cnt_s1_r;

  logic                 out_v_r;
  logic [PRED_W-1:0]    pred_x_r, pred_y_r;
  logic [CNT_W-1:0]     cnt_out_r;
  logic [PRED_W-1:0]    pred_x_nxt, pred_y_nxt;

  logic out_rdy, s1_rdy;

  // magnitude plus half divisor, times the divisor's reciprocal
  function automatic logic [PW-1:0] scaled(
    input logic signed [SW-1:0] s,
    input logic [CNT_W-1:0]     n
  );
    logic [SW-1:0] mag, num, half;
    logic [K-1:0]  recip;
    mag = s[SW-1] ? $unsigned(-s) : $unsigned(s);
    case (n)
      CNT_3:   begin half = HALF_3;  recip = RECIP_3;  end
      CNT_4:   begin half = HALF_6;  recip = RECIP_6;  end
      default: begin half = HALF_10; recip = RECIP_10; end
    endcase
    num = mag + half;
    return PW'(num) * PW'(recip);
  endfunction

  // quotient, sign, and add to the last center, wrapping to the output width
  function automatic logic [PRED_W-1:0] predict(
    input logic [PW-1:0]        prod,
    input logic signed [SW-1:0] s,
    input logic [W-1:0]         last,
    input logic [CNT_W-1:0]     n
  );
    logic [SW-1:0]        q;
    logic signed [SW:0]   delta;
    logic signed [AW-1:0] sum;
    q = prod[K +: SW];
    if (n == CNT_1 || n == CNT_2) begin
      delta = (SW+1)'(s);
    end else if (s[SW-1]) begin
      delta = -$signed({1'b0, q});
    end else begin
      delta = $signed({1'b0, q});
    end
    sum = AW'($signed({1'b0, last})) + AW'(delta);
    return sum[PRED_W-1:0];
  endfunction

  // entry fields
  assign {in_sx, in_sy, in_lx, in_ly, in_cnt} = q_data;

  // elastic stage control
  assign out_rdy = !out_v_r || out_pop;
  assign s1_rdy  = !s1_v_r || out_rdy;
  assign q_pop   = q_valid && s1_rdy;

  // stage one valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= q_valid;
    end
  end

  // stage one payload: products registered before use
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_x_r <= scaled(in_sx, in_cnt);
      prod_y_r <= scaled(in_sy, in_cnt);
      sx_r     <= in_sx;
      sy_r     <= in_sy;
      lx_r     <= in_lx;
      ly_r     <= in_ly;
      cnt_s1_r <= in_cnt;
    end
  end

  // final prediction
  assign pred_x_nxt = predict(prod_x_r, sx_r, lx_r, cnt_s1_r);
  assign pred_y_nxt = predict(prod_y_r, sy_r, ly_r, cnt_s1_r);

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s1_v_r;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_rdy && s1_v_r) begin
      pred_x_r  <= pred_x_nxt;
      pred_y_r  <= pred_y_nxt;
      cnt_out_r <= cnt_s1_r;
    end
  end

  assign out_empty         = !out_v_r;
  assign out_predicted_x   = $signed(pred_x_r);
  assign out_predicted_y   = $signed(pred_y_r);
  assign out_history_count = cnt_out_r;

endmodule

`default_nettype wire

// ===== sv/weighted_motion_predictor.sv =====
// Weighted-velocity motion predictor for one tracked object.
// Input channel: a request carries in_new_track, in_center_x and in_center_y;
// it is taken at a rising edge with in_push high and in_full low.
// Result channel: while out_empty is low the oldest prediction sits on
// out_predicted_x, out_predicted_y and out_history_count; out_pop takes it.
// Each request yields exactly one result: newest center plus a weighted
// delta over up to five stored centers, rounded half away from zero.
// A taken request passes the queue, the stage-one register and the output
// register. Throughput: one request per cycle while in_full is low; history
// update and weighted sum are combinational in the front, the back runs a
// two-stage divide/add. A two-entry queue sits between front and back, so
// in_full only rises when the result side stalls and the queue plus back
// stages fill up; a waiting result does not block new requests until then.
// Reset (rst_n low, synchronous) clears the point count and all queue and
// stage valid bits; the first request after reset starts a new track.
`default_nettype none

module weighted_motion_predictor #(
  parameter int COORD_WIDTH = wmp_pkg::COORD_W_DEF,
  parameter int QUEUE_DEPTH = wmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_new_track,
  input  logic [COORD_WIDTH-1:0]            in_center_x,
  input  logic [COORD_WIDTH-1:0]            in_center_y,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [wmp_pkg::PRED_W-1:0] out_predicted_x,
  output logic signed [wmp_pkg::PRED_W-1:0] out_predicted_y,
  output logic [wmp_pkg::CNT_W-1:0]         out_history_count
);
  import wmp_pkg::*;

  localparam int EW = entry_width(COORD_WIDTH);

  logic          accept;
  logic [EW-1:0] f_entry;
  logic [EW-1:0] q_data;
  logic          q_valid, q_pop;

  assign accept = in_push && !in_full;

  // front: history and weighted sums
  wmp_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .new_track (in_new_track),
    .center_x  (in_center_x),
    .center_y  (in_center_y),
    .entry     (f_entry)
  );

  // decoupling queue
  wmp_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (f_entry),
    .full    (in_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  // back: division, rounding and output register
  wmp_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_predicted_x   (out_predicted_x),
    .out_predicted_y   (out_predicted_y),
    .out_history_count (out_history_count)
  );

endmodule

`default_nettype wire

// ===== sv/wmp_checker.sv =====
// port-level checks for the motion predictor, bound to the top level
`default_nettype none

module wmp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic signed [wmp_pkg::PRED_W-1:0] out_predicted_x,
  input logic signed [wmp_pkg::PRED_W-1:0] out_predicted_y,
  input logic [wmp_pkg::CNT_W-1:0]         out_history_count
);
  import wmp_pkg::*;

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // reset leaves room for a request
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // a shown result always counts one to five points
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_history_count >= CNT_1 && out_history_count <= CNT_5))
    else $error("history count out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_predicted_x)
      && $stable(out_predicted_y) && $stable(out_history_count)))
    else $error("stalled result changed");

endmodule

bind weighted_motion_predictor wmp_checker u_wmp_checker (.*);

`default_nettype wire

// ===== verif/weighted_motion_predictor_chk.sv =====
// checker for the weighted motion predictor: tracks both channels, predicts and compares
module weighted_motion_predictor_chk #(
  parameter int COORD_W = wmp_pkg::COORD_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic                              in_new_track,
  input  logic [COORD_W-1:0]                in_center_x,
  input  logic [COORD_W-1:0]                in_center_y,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic signed [wmp_pkg::PRED_W-1:0] out_predicted_x,
  input  logic signed [wmp_pkg::PRED_W-1:0] out_predicted_y,
  input  logic [wmp_pkg::CNT_W-1:0]         out_history_count,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import wmp_pkg::*;

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic signed [PRED_W-1:0] px;
    logic signed [PRED_W-1:0] py;
    logic [CNT_W-1:0]         cnt;
  } prediction_t;

  // model copy of the center history, entry 0 newest
  logic [COORD_W-1:0] trail_x [HIST_DEPTH];
  logic [COORD_W-1:0] trail_y [HIST_DEPTH];
  logic [CNT_W-1:0]   track_len;
  prediction_t        predictions_q [$];

  // divide with ties rounded away from zero
  function automatic int round_half_away(input int s, input int divisor);
    int mag;
    int q;
    mag = (s < 0) ? -s : s;
    q = (2 * mag + divisor) / (2 * divisor);
    return (s < 0) ? -q : q;
  endfunction

  // newest center plus weighted velocity, wrapped to the output width
  function automatic logic signed [PRED_W-1:0] project_axis(
    input logic [COORD_W-1:0] h0, h1, h2, h3, h4,
    input logic [CNT_W-1:0]   n
  );
    int d0, d1, d2, d3, delta;
    logic [31:0] sum;
    d0 = int'(h0) - int'(h1);
    d1 = int'(h1) - int'(h2);
    d2 = int'(h2) - int'(h3);
    d3 = int'(h3) - int'(h4);
    case (n)
      CNT_2:   delta = d0;
      CNT_3:   delta = round_half_away(2 * d0 + d1, 3);
      CNT_4:   delta = round_half_away(3 * d0 + 2 * d1 + d2, 6);
      CNT_5:   delta = round_half_away(4 * d0 + 3 * d1 + 2 * d2 + d3, 10);
      default: delta = 0;
    endcase
    sum = int'(h0) + delta;
    return sum[PRED_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP)
      $display("ERROR %0t: %s", $time, msg);
    fail_count++;
  endtask

  // watch both channels each edge
  always @(posedge clk) begin
    prediction_t want;
    if (!rst_n) begin
      track_len = CNT_0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        trail_x[i] = '0;
        trail_y[i] = '0;
      end
      predictions_q.delete();
      pending <= 0;
    end else begin
      // accepted result against the oldest prediction
      if (out_pop && !out_empty) begin
        if (predictions_q.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d n=%0d with no request waiting",
                                    out_predicted_x, out_predicted_y, out_history_count));
        end else begin
          want = predictions_q.pop_front();
          if (out_predicted_x !== want.px)
            report_mismatch($sformatf("predicted_x got %0d want %0d",
                                      out_predicted_x, want.px));
          if (out_predicted_y !== want.py)
            report_mismatch($sformatf("predicted_y got %0d want %0d",
                                      out_predicted_y, want.py));
          if (out_history_count !== want.cnt)
            report_mismatch($sformatf("history_count got %0d want %0d",
                                      out_history_count, want.cnt));
          checked++;
        end
      end
      // accepted request updates the history and queues its prediction
      if (in_push && !in_full) begin
        if (in_new_track)
          track_len = CNT_0;
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
          trail_x[i] = trail_x[i-1];
          trail_y[i] = trail_y[i-1];
        end
        trail_x[0] = in_center_x;
        trail_y[0] = in_center_y;
        if (track_len != CNT_5)
          track_len++;
        want.px  = project_axis(trail_x[0], trail_x[1], trail_x[2], trail_x[3], trail_x[4],
                                track_len);
        want.py  = project_axis(trail_y[0], trail_y[1], trail_y[2], trail_y[3], trail_y[4],
                                track_len);
        want.cnt = track_len;
        predictions_q = {predictions_q, want};
      end
      pending <= predictions_q.size();
    end
  end

endmodule

// ===== verif/weighted_motion_predictor_tb.sv =====
// top of the weighted motion predictor testbench: clock, reset, stimulus and verdict
module weighted_motion_predictor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmp_pkg::*;

  localparam int COORD_W     = COORD_W_DEF;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int ITEM_TARGET = 1275;
  localparam int STALL_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_new_track = 1'b0;
  logic [COORD_W-1:0] in_center_x = '0;
  logic [COORD_W-1:0] in_center_y = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [PRED_W-1:0] out_predicted_x;
  logic signed [PRED_W-1:0] out_predicted_y;
  logic [CNT_W-1:0]   out_history_count;

  int fail_count;
  int pending;
  int checked;
  int items_sent = 0;
  int tracks_started = 0;
  int full_cycles = 0;
  int idle_cycles = 0;
  int pop_hold = 0;
  bit steady = 1'b0;

  weighted_motion_predictor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_new_track      (in_new_track),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_predicted_x   (out_predicted_x),
    .out_predicted_y   (out_predicted_y),
    .out_history_count (out_history_count)
  );

  weighted_motion_predictor_chk #(.COORD_W(COORD_W)) u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_new_track      (in_new_track),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_predicted_x   (out_predicted_x),
    .out_predicted_y   (out_predicted_y),
    .out_history_count (out_history_count),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result side: always ready in steady stretches, else short random stalls plus occasional longer holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (steady) begin
      out_pop <= 1'b1;
    end else if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_pop  <= 1'b0;
      pop_hold <= $urandom_range(1, 7);
    end else begin
      out_pop <= ($urandom_range(0, 99) >= 6);
    end
  end

  // watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && in_full)
        full_cycles <= full_cycles + 1;
      if ((in_push && !in_full) || (out_pop && !out_empty))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("weighted_motion_predictor_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [COORD_W-1:0] clamp_coord(input int v);
    if (v < 0)
      return '0;
    if (v > COORD_MAX)
      return COORD_MAX[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  // one request, with a random idle gap ahead of it outside steady stretches
  task automatic send_point(input bit fresh, input logic [COORD_W-1:0] x, y);
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_new_track <= fresh;
    in_center_x  <= x;
    in_center_y  <= y;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    if (fresh)
      tracks_started++;
  endtask

  // hold off requests until every prediction has come back
  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // stimulus
  initial begin
    int track_len, style, vx, vy, next_pause;
    int px, py;
    bit fresh;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first track after reset, flag low; alternating corners through saturation
    send_point(1'b0, 12'd4095, 12'd0);
    send_point(1'b0, 12'd0,    12'd4095);
    send_point(1'b0, 12'd4095, 12'd0);
    send_point(1'b0, 12'd0,    12'd4095);
    send_point(1'b0, 12'd4095, 12'd0);
    send_point(1'b0, 12'd0,    12'd4095);
    send_point(1'b0, 12'd4095, 12'd4095);
    // largest and smallest prediction on one-point tracks
    send_point(1'b1, 12'd0,    12'd4095);
    send_point(1'b1, 12'd4095, 12'd0);
    // four-point ties, x rounds up and y rounds down
    send_point(1'b1, 12'd100, 12'd100);
    send_point(1'b0, 12'd100, 12'd100);
    send_point(1'b0, 12'd100, 12'd100);
    send_point(1'b0, 12'd101, 12'd99);
    // five-point ties, both signs
    send_point(1'b1, 12'd100, 12'd103);
    send_point(1'b0, 12'd101, 12'd102);
    send_point(1'b0, 12'd103, 12'd100);
    send_point(1'b0, 12'd103, 12'd100);
    send_point(1'b0, 12'd103, 12'd100);
    // three-point rounding away from and toward zero
    send_point(1'b1, 12'd0, 12'd10);
    send_point(1'b0, 12'd1, 12'd9);
    send_point(1'b0, 12'd3, 12'd10);
    // back-to-back new tracks stay at one point
    send_point(1'b1, 12'd2048, 12'd2048);
    send_point(1'b1, 12'd2048, 12'd2048);

    // random tracks, mostly smooth motion
    next_pause = 400;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause += 450;
      end
      steady = (items_sent >= 650 && items_sent < 850);
      track_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
      style = $urandom_range(0, 9);
      fresh = ($urandom_range(0, 9) != 0);
      px = $urandom_range(0, COORD_MAX);
      py = $urandom_range(0, COORD_MAX);
      vx = int'($urandom_range(0, 128)) - 64;
      vy = int'($urandom_range(0, 128)) - 64;
      for (int k = 0; k < track_len; k++) begin
        send_point(fresh && k == 0, clamp_coord(px), clamp_coord(py));
        case (style)
          7: begin
            // noise
            px = $urandom_range(0, COORD_MAX);
            py = $urandom_range(0, COORD_MAX);
          end
          8: begin
            // frame corners
            px = $urandom_range(0, 1) * COORD_MAX;
            py = $urandom_range(0, 1) * COORD_MAX;
          end
          9: begin
            // abrupt turns
            vx = int'($urandom_range(0, 2048)) - 1024;
            vy = int'($urandom_range(0, 2048)) - 1024;
            px = int'(clamp_coord(px + vx));
            py = int'(clamp_coord(py + vy));
          end
          default: begin
            vx += int'($urandom_range(0, 4)) - 2;
            vy += int'($urandom_range(0, 4)) - 2;
            px = int'(clamp_coord(px + vx));
            py = int'(clamp_coord(py + vy));
          end
        endcase
      end
    end
    steady = 1'b0;

    // drain, then allow for the pipeline latency
    wait_drained();
    repeat (8) @(posedge clk);

    $display("run covered %0d requests in %0d fresh tracks, %0d predictions checked",
             items_sent, tracks_started, checked);
    $display("requests held back by full on %0d cycles", full_cycles);
    if (fail_count == 0) begin
      $display("weighted_motion_predictor_tb: PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("weighted_motion_predictor_tb: FAIL");
    end
    $finish;
  end

endmodule
